>>> rtl/rvrr_pkg.sv
// Package: sizes, word types, controller states and command/status bundles of the reorder unit.
`timescale 1ns / 1ps
package rvrr_pkg;

  localparam int CACHE_SLOTS = 32;  // power of two: slot index is the low bits of the sequence
  localparam int IDX_W       = $clog2(CACHE_SLOTS);
  localparam int CNT_W       = $clog2(CACHE_SLOTS + 1);
  localparam int SEQ_W       = 16;
  localparam int HANDLE_W    = 16;

  typedef struct packed {
    logic                is_video;
    logic [SEQ_W-1:0]    seq_number;
    logic [HANDLE_W-1:0] packet_handle;
  } in_word_t;

  typedef struct packed {
    logic                out_is_video;
    logic [SEQ_W-1:0]    out_seq_number;
    logic [HANDLE_W-1:0] out_handle;
    logic                last_of_run;
  } out_word_t;

  typedef struct packed {
    logic [SEQ_W-1:0]    seq;
    logic [HANDLE_W-1:0] handle;
  } slot_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_RUN
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic rd_from_in;   // read address from the arriving word
    logic rd_next;      // read address cur_seq + 1, else cur_seq
    logic ld_audio;
    logic cap_video;
    logic wr_slot;
    logic emit_first;
    logic run_start;
    logic run_step;
    logic run_end;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_is_video;
    logic hit;
    logic is_next;
    logic started;
    logic out_free;
    logic run_full;
  } sts_t;

  function automatic logic [IDX_W-1:0] slot_idx(input logic [SEQ_W-1:0] s);
    return s[IDX_W-1:0];
  endfunction

endpackage

>>> rtl/rvrr_if.sv
// Handshake channel interfaces for arriving packets and released words.
`timescale 1ns / 1ps
interface rvrr_in_if;
  import rvrr_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rvrr_out_if;
  import rvrr_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/rtp_video_reorder_release_unit.sv
// Top level of the RTP video reorder and release unit.
//
//  channel | dir | handshake          | word
//  --------+-----+--------------------+-------------------------------------------------
//  pkt_i   | in  | valid/ready        | is_video, seq_number, packet_handle
//  rel_o   | out | valid/ready        | out_is_video, out_seq_number, out_handle,
//          |     |                    | last_of_run
//
// Audio: one word per cycle while the output register can take it, straight into that register.
// Video: an accept in the idle state, then a lookup on the slot RAM; a released run
// then reads one slot RAM entry per word (single read port).
// Reset clears the slot valid bits at once; no clearing pass.
// A stalled output register holds the run in place; pkt_i.ready is low until the
// item's work is done and the output register can take a word.
`timescale 1ns / 1ps
module rtp_video_reorder_release_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  rvrr_in_if.sink       pkt_i,
  rvrr_out_if.source    rel_o
);
  import rvrr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rvrr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  rvrr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_valid_i  (pkt_i.valid),
    .in_data_i   (pkt_i.data),
    .out_ready_i (rel_o.ready),
    .out_valid_o (rel_o.valid),
    .out_data_o  (rel_o.data)
  );

  assign pkt_i.ready = cmd.in_ready;

  // at most one load of the output register per cycle
  a_one_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.ld_audio, cmd.emit_first, cmd.run_step, cmd.run_end}))
    else $error("more than one output load in a cycle");

  // a word is never loaded over one that is still waiting
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.ld_audio || cmd.emit_first || cmd.run_step || cmd.run_end) |-> sts.out_free)
    else $error("output word overwritten");

  // a video word keeps the input closed during its lookup
  a_video_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pkt_i.valid && pkt_i.ready && pkt_i.data.is_video) |=> !pkt_i.ready)
    else $error("input taken during lookup");

  // audio is always a single, final word
  a_audio_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rel_o.valid && !rel_o.data.out_is_video) |-> rel_o.data.last_of_run)
    else $error("audio word without last_of_run");

endmodule

>>> rtl/rvrr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rvrr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/rvrr_ctrl.sv
// Controller state machine: sequences lookup, cache write and run release.
`timescale 1ns / 1ps
module rvrr_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rvrr_pkg::sts_t  sts_i,
  output rvrr_pkg::cmd_t  cmd_o
);
  import rvrr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready   = sts_i.out_free;
        cmd_o.rd_from_in = 1'b1;
        if (sts_i.in_valid && sts_i.out_free) begin
          if (sts_i.in_is_video) begin
            cmd_o.cap_video = 1'b1;
            state_d         = ST_LOOKUP;
          end else begin
            cmd_o.ld_audio = 1'b1;
          end
        end
      end
      ST_LOOKUP: begin
        // rewriting the same slot during a hold is harmless
        cmd_o.wr_slot = !sts_i.hit;
        if (!sts_i.started) begin
          if (sts_i.out_free) begin
            cmd_o.emit_first = 1'b1;
            state_d          = ST_IDLE;
          end
        end else if (sts_i.is_next) begin
          cmd_o.run_start = 1'b1;
          cmd_o.rd_next   = 1'b1;
          state_d         = ST_RUN;
        end else begin
          // stale, repeated or ahead of a gap: nothing released
          state_d = ST_IDLE;
        end
      end
      ST_RUN: begin
        // one word is always pending; it goes out once the next slot is known
        if (sts_i.hit && !sts_i.run_full) begin
          if (sts_i.out_free) begin
            cmd_o.run_step = 1'b1;
            cmd_o.rd_next  = 1'b1;
          end
        end else if (sts_i.out_free) begin
          cmd_o.run_end = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/rvrr_dp.sv
// Datapath: slot cache, valid bits, sequence state, pending word and output register.
`timescale 1ns / 1ps
module rvrr_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rvrr_pkg::cmd_t      cmd_i,
  output rvrr_pkg::sts_t      sts_o,
  input  logic                in_valid_i,
  input  rvrr_pkg::in_word_t  in_data_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output rvrr_pkg::out_word_t out_data_o
);
  import rvrr_pkg::*;

  logic [CACHE_SLOTS-1:0] valid_q, valid_d;
  logic                   started_q, started_d;
  logic [SEQ_W-1:0]       last_q, last_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic                   out_valid_q, out_valid_d;
  out_word_t              out_q, out_d;
  logic [SEQ_W-1:0]       cur_seq_q, cur_seq_d;
  logic [HANDLE_W-1:0]    in_handle_q, in_handle_d;
  logic [HANDLE_W-1:0]    pend_q, pend_d;

  logic [SEQ_W-1:0] cur_inc;
  logic [SEQ_W-1:0] cur_dec;
  logic [IDX_W-1:0] cur_idx;
  logic [IDX_W-1:0] raddr;
  slot_t            rd_slot;
  slot_t            wr_slot;
  logic             hit;
  logic             out_free;

  assign cur_inc = cur_seq_q + 16'd1;
  assign cur_dec = cur_seq_q - 16'd1;
  assign cur_idx = slot_idx(cur_seq_q);

  always_comb begin
    if (cmd_i.rd_from_in) begin
      raddr = slot_idx(in_data_i.seq_number);
    end else if (cmd_i.rd_next) begin
      raddr = slot_idx(cur_inc);
    end else begin
      raddr = cur_idx;
    end
  end

  assign wr_slot = '{seq: cur_seq_q, handle: in_handle_q};

  rvrr_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (CACHE_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_slot),
    .waddr_i (cur_idx),
    .wdata_i (wr_slot),
    .raddr_i (raddr),
    .rdata_o (rd_slot)
  );

  assign hit      = valid_q[cur_idx] && (rd_slot.seq == cur_seq_q);
  assign out_free = !out_valid_q || out_ready_i;

  // only the successor of the last released number starts a run;
  // every other number is at or behind it, or leaves a gap
  assign sts_o = '{
    in_valid:    in_valid_i,
    in_is_video: in_data_i.is_video,
    hit:         hit,
    is_next:     started_q && (cur_seq_q == 16'(last_q + 16'd1)),
    started:     started_q,
    out_free:    out_free,
    run_full:    count_q == CNT_W'(CACHE_SLOTS)
  };

  always_comb begin
    valid_d     = valid_q;
    started_d   = started_q;
    last_d      = last_q;
    count_d     = count_q;
    cur_seq_d   = cur_seq_q;
    in_handle_d = in_handle_q;
    pend_d      = pend_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (cmd_i.cap_video) begin
      cur_seq_d   = in_data_i.seq_number;
      in_handle_d = in_data_i.packet_handle;
    end
    if (cmd_i.wr_slot) begin
      valid_d[cur_idx] = 1'b1;
    end
    if (cmd_i.ld_audio) begin
      out_d       = '{out_is_video: 1'b0, out_seq_number: in_data_i.seq_number,
                      out_handle: in_data_i.packet_handle, last_of_run: 1'b1};
      out_valid_d = 1'b1;
    end
    if (cmd_i.emit_first) begin
      started_d   = 1'b1;
      last_d      = cur_seq_q;
      out_d       = '{out_is_video: 1'b1, out_seq_number: cur_seq_q,
                      out_handle: in_handle_q, last_of_run: 1'b1};
      out_valid_d = 1'b1;
    end
    if (cmd_i.run_start) begin
      // a duplicate keeps the handle stored first
      pend_d    = hit ? rd_slot.handle : in_handle_q;
      cur_seq_d = cur_inc;
      count_d   = CNT_W'(1);
    end
    if (cmd_i.run_step) begin
      out_d       = '{out_is_video: 1'b1, out_seq_number: cur_dec,
                      out_handle: pend_q, last_of_run: 1'b0};
      out_valid_d = 1'b1;
      pend_d      = rd_slot.handle;
      cur_seq_d   = cur_inc;
      count_d     = count_q + CNT_W'(1);
    end
    if (cmd_i.run_end) begin
      out_d       = '{out_is_video: 1'b1, out_seq_number: cur_dec,
                      out_handle: pend_q, last_of_run: 1'b1};
      out_valid_d = 1'b1;
      last_d      = cur_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      started_q   <= 1'b0;
      last_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      started_q   <= started_d;
      last_q      <= last_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q       <= out_d;
    cur_seq_q   <= cur_seq_d;
    in_handle_q <= in_handle_d;
    pend_q      <= pend_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
